/* design/unc_net_path_checker_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the network path checker
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef UNC_NET_PATH_CHECKER_TOP_MACROS_SVH
`define UNC_NET_PATH_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// plain property check
`define NPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("npc assertion failed");

// same-cycle implication
`define NPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npc implication failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npc next-cycle check failed");

`else

`define NPC_ASSERT(lbl, clk, rst_n, prop)
`define NPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg
// Types, register indexes and character constants of the path checker.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

	// register indexes on the configuration port
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAX_PATH_LEN      = 2'd0;
	localparam cfg_idx_t CFG_COMPUTER_NAME_LEN = 2'd1;
	localparam cfg_idx_t CFG_SHARE_NAME_LEN    = 2'd2;

	localparam int CFG_DATA_W = 11;
	localparam int LEN_W      = 11;
	localparam int NAME_W     = 8;
	localparam int CHAR_W     = 8;

	// register reset values
	localparam logic [LEN_W-1:0]  MAX_PATH_LEN_RST      = 11'd256;
	localparam logic [NAME_W-1:0] COMPUTER_NAME_LEN_RST = 8'd15;
	localparam logic [NAME_W-1:0] SHARE_NAME_LEN_RST    = 8'd12;

	// characters
	localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] FWD_SLASH   = 8'h2F;
	localparam logic [CHAR_W-1:0] BACK_SLASH  = 8'h5C;
	localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] SLASHES_START = 2'd2;
	localparam logic [1:0] SLASHES_SHARE = 2'd1;

	typedef enum logic [1:0] {
		PH_SLASH = 2'd0,
		PH_COMP  = 2'd1,
		PH_SHARE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_path_len;
		logic [NAME_W-1:0] computer_name_len;
		logic [NAME_W-1:0] share_name_len;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [1:0]        slashes_left;
		logic [NAME_W-1:0] name_left;
		logic [LEN_W-1:0]  length_left;
		logic              prev_slash;
	} path_st_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              path_end;
		logic              path_bad;
	} res_t;

endpackage

`default_nettype wire

/* design/npc_if.sv */
// ----------------------------------------------------------------------------
// npc_if
// Valid/ready stream channels for path bytes and translated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface npc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       path_end;
	logic       path_bad;

	modport source (output valid, output out_char, output path_end, output path_bad,
		input ready);
	modport sink   (input valid, input out_char, input path_end, input path_bad,
		output ready);
endinterface

`default_nettype wire

/* design/unc_net_path_checker_top.sv */
// ----------------------------------------------------------------------------
// unc_net_path_checker_top
// Streaming checker and translator for network paths of the form \\name\share.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a path enter on in_ch, one per transfer, ending with a zero byte.
//   Every byte gives exactly one result on out_ch: the translated byte
//   ('/' to '\', a-z raised), or a closing result with out_char zero and
//   path_end set, with path_bad set when the path was rejected.
//   After a closing result the next byte starts a new path.
//   Each byte is held in the input register, then its result in the result
//   register, from which it transfers on out_ch. Throughput: one byte per
//   cycle while out_ch does not stall; the state update between the two
//   registers is combinational.
//   When out_ch stalls, the result register holds and the input register
//   still takes one more byte; in_ch.ready then drops until out_ch drains.
//   Reset (arst_n low) empties both registers, loads the register defaults
//   (path length 256, computer name 15, share name 12) and restarts the path.
//   Registers are written through cfg_we/cfg_idx/cfg_data while the block
//   is idle; a new path length takes effect at once only before a path starts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unc_net_path_checker_top_macros.svh"

module unc_net_path_checker_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	npc_in_if.sink                 in_ch,
	npc_out_if.source              out_ch,
	input  wire logic              cfg_we,
	input  wire npc_pkg::cfg_idx_t cfg_idx,
	input  wire logic [10:0]       cfg_data
);
	import npc_pkg::*;

	logic              v_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              v_s2;
	res_t              res_s2;
	res_t              res;
	logic              adv;
	logic              in_xfer;

	// stage 1 moves into the result register when that is free or draining
	assign adv          = v_s1 && (!v_s2 || out_ch.ready);
	assign in_ch.ready  = !v_s1 || adv;
	assign in_xfer      = in_ch.valid && in_ch.ready;

	npc_ctx u_ctx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.commit   (adv),
		.in_char  (char_s1),
		.res      (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= in_ch.in_char;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid    = v_s2;
	assign out_ch.out_char = res_s2.out_char;
	assign out_ch.path_end = res_s2.path_end;
	assign out_ch.path_bad = res_s2.path_bad;

	// a rejection always closes the path
	`NPC_ASSERT_IMPL(a_bad_closes, clk, arst_n, v_s2 && res_s2.path_bad, res_s2.path_end)
	// an accepted byte is never emitted as zero
	`NPC_ASSERT_IMPL(a_byte_nonzero, clk, arst_n, v_s2 && !res_s2.path_end,
		res_s2.out_char != CHAR_NUL)
	// an empty input register always takes a byte
	`NPC_ASSERT_IMPL(a_empty_ready, clk, arst_n, !v_s1, in_ch.ready)

endmodule

`default_nettype wire

/* design/npc_step.sv */
// ----------------------------------------------------------------------------
// npc_step
// One byte of path parsing: translate, check budgets, give next state/result.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_step (
	input  wire logic [7:0]       in_char,
	input  wire npc_pkg::path_st_t st,
	input  wire npc_pkg::cfg_t     cfg,
	output npc_pkg::path_st_t      nst,
	output npc_pkg::res_t          res
);
	import npc_pkg::*;

	logic [CHAR_W-1:0] tchar;
	logic              is_slash;
	logic              bad;
	logic              done;
	logic [NAME_W-1:0] names;
	path_st_t          upd;
	path_st_t          restart;

	// translate: forward slash to backslash, lower case raised
	always_comb begin
		priority if (in_char == FWD_SLASH) begin
			tchar = BACK_SLASH;
		end else if (in_char >= LOWER_A && in_char <= LOWER_Z) begin
			tchar = in_char - CASE_OFFSET;
		end else begin
			tchar = in_char;
		end
	end

	assign is_slash = (tchar == BACK_SLASH);

	// state after a path closes
	always_comb begin
		restart              = '0;
		restart.phase        = PH_SLASH;
		restart.slashes_left = SLASHES_START;
		restart.length_left  = cfg.max_path_len;
	end

	// budget checks and phase tracking
	always_comb begin
		bad             = 1'b0;
		names           = st.name_left;
		upd             = st;
		upd.length_left = st.length_left - 1'b1;
		upd.prev_slash  = is_slash;
		priority if (in_char == CHAR_NUL) begin
			bad = 1'b0;
		end else if (st.length_left == '0) begin
			bad = 1'b1;
		end else if (is_slash) begin
			if (st.slashes_left == 2'd0) begin
				bad = 1'b1;
			end else begin
				upd.slashes_left = st.slashes_left - 2'd1;
			end
		end else begin
			if (st.prev_slash) begin
				if (st.slashes_left != 2'd0) begin
					bad = 1'b1;
				end else begin
					unique case (st.phase)
						PH_SLASH: begin
							upd.phase        = PH_COMP;
							names            = cfg.computer_name_len;
							upd.slashes_left = SLASHES_SHARE;
						end
						PH_COMP: begin
							upd.phase        = PH_SHARE;
							names            = cfg.share_name_len;
							upd.slashes_left = 2'd0;
						end
						default: begin
							upd.phase = st.phase;
						end
					endcase
				end
			end
			if (!bad) begin
				if (names == '0) begin
					bad = 1'b1;
				end else begin
					upd.name_left = names - 1'b1;
				end
			end
		end
	end

	assign done = (in_char == CHAR_NUL) || bad;

	// result and next state
	always_comb begin
		if (done) begin
			nst          = restart;
			res.out_char = CHAR_NUL;
			res.path_end = 1'b1;
			res.path_bad = bad;
		end else begin
			nst          = upd;
			res.out_char = tchar;
			res.path_end = 1'b0;
			res.path_bad = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* design/npc_ctx.sv */
// ----------------------------------------------------------------------------
// npc_ctx
// Configuration registers and path state; commits one parsed byte per cycle while commit is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unc_net_path_checker_top_macros.svh"

module npc_ctx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire npc_pkg::cfg_idx_t cfg_idx,
	input  wire logic [10:0]       cfg_data,
	input  wire logic              commit,
	input  wire logic [7:0]        in_char,
	output npc_pkg::res_t          res
);
	import npc_pkg::*;

	cfg_t     cfg_q;
	path_st_t st_q;
	path_st_t nst;

	npc_step u_step (
		.in_char (in_char),
		.st      (st_q),
		.cfg     (cfg_q),
		.nst     (nst),
		.res     (res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_path_len      <= MAX_PATH_LEN_RST;
			cfg_q.computer_name_len <= COMPUTER_NAME_LEN_RST;
			cfg_q.share_name_len    <= SHARE_NAME_LEN_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_MAX_PATH_LEN) begin
				cfg_q.max_path_len <= cfg_data[LEN_W-1:0];
			end
			if (cfg_idx == CFG_COMPUTER_NAME_LEN) begin
				cfg_q.computer_name_len <= cfg_data[NAME_W-1:0];
			end
			if (cfg_idx == CFG_SHARE_NAME_LEN) begin
				cfg_q.share_name_len <= cfg_data[NAME_W-1:0];
			end
		end
	end

	// path state; a new length limit reloads only before the first byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_SLASH, slashes_left: SLASHES_START, name_left: '0,
				length_left: MAX_PATH_LEN_RST, prev_slash: 1'b0};
		end else if (commit) begin
			st_q <= nst;
		end else if (cfg_we && cfg_idx == CFG_MAX_PATH_LEN && st_q.phase == PH_SLASH
				&& st_q.slashes_left == SLASHES_START) begin
			st_q.length_left <= cfg_data[LEN_W-1:0];
		end
	end

	// a closed path leaves the start state behind
	`NPC_ASSERT_NEXT(a_end_restarts, clk, arst_n, commit && res.path_end,
		st_q.phase == PH_SLASH && st_q.slashes_left == SLASHES_START && !st_q.prev_slash)
	// no slash is ever taken inside the share name
	`NPC_ASSERT_IMPL(a_share_no_slash, clk, arst_n, st_q.prev_slash, st_q.phase != PH_SHARE)
	// the leading slashes carry no name budget
	`NPC_ASSERT_IMPL(a_slash_no_budget, clk, arst_n, st_q.phase == PH_SLASH, st_q.name_left == '0)

endmodule

`default_nettype wire
